FILE: sv/jse_pkg.sv
// Shared types, codes and helper functions for the JSON string escaper.
// Used by jse_decode, jse_emit and json_string_escaper_utf8_check.
// No dependencies.
package jse_pkg;

    // Operation codes of an input request.
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // Character constants.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LC_N  = 8'h6E;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_U  = 8'h75;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LC_A  = 8'h61;

    // UTF-8 lead and continuation bounds.
    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;
    localparam logic [7:0] LEAD_ED  = 8'hED;
    localparam logic [7:0] CONT_LO  = 8'h80;
    localparam logic [7:0] CONT_HI  = 8'hBF;
    localparam logic [7:0] E0_LO    = 8'hA0;
    localparam logic [7:0] ED_HI    = 8'h9F;
    localparam logic [7:0] F0_LO    = 8'h90;
    localparam logic [7:0] F4_HI    = 8'h8F;

    // Number of output units a single request can produce.
    localparam int UNITS = 4;

    // How one unit expands into output characters.
    typedef enum logic [1:0] {
        U_NONE,   // empty slot
        U_RAW,    // the byte itself
        U_ESC2,   // backslash then the byte
        U_UESC    // backslash-u-00 and two hex digits of the byte
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] val;
    } t_unit;

    // Everything one request has to send, in order.
    typedef struct packed {
        t_unit [UNITS-1:0] units;
        logic  [2:0]       n;
    } t_run;

    // Control part of the UTF-8 hold state.
    typedef struct packed {
        logic [7:0] lead;
        logic [1:0] count;
        logic [2:0] explen;
    } t_hold;

    // Lower-case hex digit of a nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        if (v < 4'd10) begin
            return CH_ZERO + {4'd0, v};
        end
        return CH_LC_A + {4'd0, v} - 8'd10;
    endfunction

endpackage

FILE: sv/json_string_escaper_utf8_check.sv
// JSON string escaper with UTF-8 check. Each input request (begin, data byte, end) is
// decoded in the cycle it is accepted; its characters go out from a result register one
// per cycle while the output is ready; the input is stalled until they have gone
// (one for plain ASCII, two per short escape, six per backslash-u escape, up to 24 for a
// broken sequence and its failing byte); the serializer is the limit. A request that
// only extends a held UTF-8 sequence yields nothing. The next request is accepted in the
// cycle the last character of the previous run goes.
module json_string_escaper_utf8_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    jse_pkg::t_hold  r_hold;
    jse_pkg::t_hold  n_hold;
    logic [1:0][7:0] r_cont;
    logic [1:0][7:0] n_cont;
    jse_pkg::t_run   w_run;
    logic            w_accept;
    logic            w_load;
    logic            w_busy;
    logic            w_done;

    // Decode against the current hold state.
    jse_decode u_decode (
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .i_hold      (r_hold),
        .i_cont      (r_cont),
        .o_hold      (n_hold),
        .o_cont      (n_cont),
        .o_run       (w_run)
    );

    // A request is taken when the result register is free or drains this cycle.
    assign o_in_ready = !w_busy || w_done;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = w_accept && (w_run.n != 3'd0);

    jse_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_run         (w_run),
        .o_busy        (w_busy),
        .o_done        (w_done),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    // Hold state control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
        end else if (w_accept) begin
            r_hold <= n_hold;
        end
    end

    // Held continuation bytes are only read below the held count.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cont <= n_cont;
        end
    end

`ifndef NO_ASSERTIONS
    // Never more than two continuations are held.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold.count != 2'd3)
        else $error("held continuation count out of range");

    // With nothing held, the continuation count is zero.
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold.explen == 3'd0) |-> (r_hold.count == 2'd0))
        else $error("continuations held without a lead");

    // Held count stays below the number of continuations the lead calls for.
    a_count_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold.explen != 3'd0) |-> (({1'b0, r_hold.count} + 3'd2) <= r_hold.explen))
        else $error("held sequence overran its length");

    // A request that yields characters starts sending them in the next cycle.
    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_out_valid)
        else $error("accepted run not presented");
`endif

endmodule

FILE: sv/jse_decode.sv
// Combinational decode of one request: next hold state and the run of units to send.
// Depends on jse_pkg.
module jse_decode (
    input  logic [1:0]          i_op,
    input  logic [7:0]          i_data_byte,
    input  jse_pkg::t_hold      i_hold,
    input  logic [1:0][7:0]     i_cont,
    output jse_pkg::t_hold      o_hold,
    output logic [1:0][7:0]     o_cont,
    output jse_pkg::t_run       o_run
);

    // Unit for a byte that is not part of a sequence.
    function automatic jse_pkg::t_unit fresh_unit(input logic [7:0] c);
        jse_pkg::t_unit u;
        u.val  = c;
        u.kind = jse_pkg::U_UESC;
        case (c)
            jse_pkg::CH_QUOTE: u.kind = jse_pkg::U_ESC2;
            jse_pkg::CH_BSL:   u.kind = jse_pkg::U_ESC2;
            jse_pkg::CH_NL: begin
                u.kind = jse_pkg::U_ESC2;
                u.val  = jse_pkg::CH_LC_N;
            end
            jse_pkg::CH_TAB: begin
                u.kind = jse_pkg::U_ESC2;
                u.val  = jse_pkg::CH_LC_T;
            end
            jse_pkg::CH_CR: begin
                u.kind = jse_pkg::U_ESC2;
                u.val  = jse_pkg::CH_LC_R;
            end
            default: begin
                if (c >= 8'h20 && c < 8'h80) begin
                    u.kind = jse_pkg::U_RAW;
                end
            end
        endcase
        return u;
    endfunction

    // Sequence length started by a lead byte, zero when it is no lead.
    function automatic logic [2:0] lead_len(input logic [7:0] c);
        if (c inside {[jse_pkg::LEAD2_LO:jse_pkg::LEAD2_HI]}) begin
            return 3'd2;
        end
        if (c inside {[jse_pkg::LEAD3_LO:jse_pkg::LEAD3_HI]}) begin
            return 3'd3;
        end
        if (c inside {[jse_pkg::LEAD4_LO:jse_pkg::LEAD4_HI]}) begin
            return 3'd4;
        end
        return 3'd0;
    endfunction

    logic [7:0] c;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [2:0] cnt;
    logic [2:0] len;
    logic       flush;

    assign c   = i_data_byte;
    assign len = lead_len(i_data_byte);

    // Range allowed for the next continuation byte.
    always_comb begin
        lo = jse_pkg::CONT_LO;
        hi = jse_pkg::CONT_HI;
        if (i_hold.count == 2'd0) begin
            if (i_hold.lead == jse_pkg::LEAD3_LO) lo = jse_pkg::E0_LO;
            if (i_hold.lead == jse_pkg::LEAD_ED)  hi = jse_pkg::ED_HI;
            if (i_hold.lead == jse_pkg::LEAD4_LO) lo = jse_pkg::F0_LO;
            if (i_hold.lead == jse_pkg::LEAD4_HI) hi = jse_pkg::F4_HI;
        end
    end

    // A held sequence is escaped on end, or on a byte that breaks it.
    assign flush = (i_hold.explen != 3'd0) &&
                   ((i_op == jse_pkg::OP_END) ||
                    ((i_op == jse_pkg::OP_DATA) && (c < lo || c > hi)));

    // Build the run and the next hold state.
    always_comb begin
        o_hold = i_hold;
        o_cont = i_cont;
        o_run  = '0;
        cnt    = 3'd0;

        if (flush) begin
            o_run.units[cnt[1:0]] = '{jse_pkg::U_UESC, i_hold.lead};
            cnt = cnt + 3'd1;
            if (i_hold.count >= 2'd1) begin
                o_run.units[cnt[1:0]] = '{jse_pkg::U_UESC, i_cont[0]};
                cnt = cnt + 3'd1;
            end
            if (i_hold.count >= 2'd2) begin
                o_run.units[cnt[1:0]] = '{jse_pkg::U_UESC, i_cont[1]};
                cnt = cnt + 3'd1;
            end
            o_hold = '0;
        end

        case (i_op)
            jse_pkg::OP_BEGIN: begin
                o_hold = '0;
                o_run.units[cnt[1:0]] = '{jse_pkg::U_RAW, jse_pkg::CH_QUOTE};
                cnt = cnt + 3'd1;
            end
            jse_pkg::OP_END: begin
                o_run.units[cnt[1:0]] = '{jse_pkg::U_RAW, jse_pkg::CH_QUOTE};
                cnt = cnt + 3'd1;
            end
            jse_pkg::OP_DATA: begin
                if (i_hold.explen == 3'd0 || flush) begin
                    // Fresh byte: either starts a sequence or is sent now.
                    if (len != 3'd0) begin
                        o_hold.lead   = c;
                        o_hold.count  = 2'd0;
                        o_hold.explen = len;
                    end else begin
                        o_run.units[cnt[1:0]] = fresh_unit(c);
                        cnt = cnt + 3'd1;
                    end
                end else if (({1'b0, i_hold.count} + 3'd2) >= i_hold.explen) begin
                    // Sequence complete: send it verbatim.
                    o_run.units[cnt[1:0]] = '{jse_pkg::U_RAW, i_hold.lead};
                    cnt = cnt + 3'd1;
                    if (i_hold.count >= 2'd1) begin
                        o_run.units[cnt[1:0]] = '{jse_pkg::U_RAW, i_cont[0]};
                        cnt = cnt + 3'd1;
                    end
                    if (i_hold.count >= 2'd2) begin
                        o_run.units[cnt[1:0]] = '{jse_pkg::U_RAW, i_cont[1]};
                        cnt = cnt + 3'd1;
                    end
                    o_run.units[cnt[1:0]] = '{jse_pkg::U_RAW, c};
                    cnt = cnt + 3'd1;
                    o_hold = '0;
                end else begin
                    // Keep the continuation and wait for more.
                    o_cont[i_hold.count[0]] = c;
                    o_hold.count = i_hold.count + 2'd1;
                end
            end
            default: begin
                o_hold = i_hold;
            end
        endcase
        o_run.n = cnt;
    end

endmodule

FILE: sv/jse_emit.sv
// Result register and serializer: sends the characters of one run, one per cycle
// while the output is ready. Depends on jse_pkg.
module jse_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  jse_pkg::t_run  i_run,
    output logic           o_busy,
    output logic           o_done,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_last_of_run
);

    logic                          r_busy;
    jse_pkg::t_unit [jse_pkg::UNITS-1:0] r_units;
    logic [2:0]                    r_n;
    logic [1:0]                    r_ui;
    logic [2:0]                    r_ci;

    jse_pkg::t_unit                cur;
    logic [2:0]                    cur_len;
    logic                          unit_end;
    logic                          run_end;

    assign cur = r_units[r_ui];

    // Characters in the current unit.
    always_comb begin
        case (cur.kind)
            jse_pkg::U_ESC2: cur_len = 3'd2;
            jse_pkg::U_UESC: cur_len = 3'd6;
            default:         cur_len = 3'd1;
        endcase
    end

    // Character at the current position.
    always_comb begin
        o_out_byte = cur.val;
        case (cur.kind)
            jse_pkg::U_ESC2: begin
                if (r_ci == 3'd0) o_out_byte = jse_pkg::CH_BSL;
            end
            jse_pkg::U_UESC: begin
                case (r_ci)
                    3'd0:    o_out_byte = jse_pkg::CH_BSL;
                    3'd1:    o_out_byte = jse_pkg::CH_LC_U;
                    3'd4:    o_out_byte = jse_pkg::hex_digit(cur.val[7:4]);
                    3'd5:    o_out_byte = jse_pkg::hex_digit(cur.val[3:0]);
                    default: o_out_byte = jse_pkg::CH_ZERO;
                endcase
            end
            default: o_out_byte = cur.val;
        endcase
    end

    assign unit_end      = (r_ci == cur_len - 3'd1);
    assign run_end       = unit_end && ({1'b0, r_ui} == r_n - 3'd1);
    assign o_out_valid   = r_busy;
    assign o_last_of_run = run_end;
    assign o_busy        = r_busy;
    assign o_done        = r_busy && i_out_ready && run_end;

    // Control: load a new run, or step through the current one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ui   <= 2'd0;
            r_ci   <= 3'd0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_ui   <= 2'd0;
            r_ci   <= 3'd0;
        end else if (r_busy && i_out_ready) begin
            if (run_end) begin
                r_busy <= 1'b0;
            end else if (unit_end) begin
                r_ui <= r_ui + 2'd1;
                r_ci <= 3'd0;
            end else begin
                r_ci <= r_ci + 3'd1;
            end
        end
    end

    // Payload of the run.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_units <= i_run.units;
            r_n     <= i_run.n;
        end
    end

endmodule

FILE: bench/json_string_escaper_utf8_check_chk.sv
// Checker for json_string_escaper_utf8_check: watches both channels, predicts the escaped
// output characters of every accepted request and compares them in order.
// Depends on jse_pkg for the operation codes and character constants.
`timescale 1ns / 1ps

module json_string_escaper_utf8_check_chk (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_data_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_last_of_run,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_out_char;

    // Characters still owed by the block, oldest first.
    t_out_char  owed_chars[$];
    // Characters of the request being predicted.
    logic [7:0] req_chars[$];

    // Mirror of the UTF-8 hold state.
    logic [7:0] seq_lead;
    logic [7:0] seq_cont [2];
    logic [1:0] seq_cont_cnt;
    logic [2:0] seq_len;

    int fails = 0;

    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return jse_pkg::CH_ZERO + 8'(v);
        end
        return jse_pkg::CH_LC_A + 8'(v) - 8'd10;
    endfunction

    function automatic void put_uesc(input logic [7:0] c);
        req_chars.push_back(jse_pkg::CH_BSL);
        req_chars.push_back(jse_pkg::CH_LC_U);
        req_chars.push_back(jse_pkg::CH_ZERO);
        req_chars.push_back(jse_pkg::CH_ZERO);
        req_chars.push_back(nibble_char(c[7:4]));
        req_chars.push_back(nibble_char(c[3:0]));
    endfunction

    function automatic void put_esc2(input logic [7:0] c);
        req_chars.push_back(jse_pkg::CH_BSL);
        req_chars.push_back(c);
    endfunction

    function automatic void drop_seq();
        seq_lead     = 8'h00;
        seq_cont[0]  = 8'h00;
        seq_cont[1]  = 8'h00;
        seq_cont_cnt = 2'd0;
        seq_len      = 3'd0;
    endfunction

    // A held sequence that cannot complete is escaped byte by byte.
    function automatic void spill_seq();
        if (seq_len == 3'd0) begin
            return;
        end
        put_uesc(seq_lead);
        for (int k = 0; k < int'(seq_cont_cnt) && k < 2; k++) begin
            put_uesc(seq_cont[k]);
        end
        drop_seq();
    endfunction

    // A byte seen with nothing held.
    function automatic void scan_fresh(input logic [7:0] c);
        case (c)
            jse_pkg::CH_QUOTE: put_esc2(jse_pkg::CH_QUOTE);
            jse_pkg::CH_BSL:   put_esc2(jse_pkg::CH_BSL);
            jse_pkg::CH_NL:    put_esc2(jse_pkg::CH_LC_N);
            jse_pkg::CH_TAB:   put_esc2(jse_pkg::CH_LC_T);
            jse_pkg::CH_CR:    put_esc2(jse_pkg::CH_LC_R);
            default: begin
                if (c < 8'h20) begin
                    put_uesc(c);
                end else if (c < 8'h80) begin
                    req_chars.push_back(c);
                end else if (c >= jse_pkg::LEAD2_LO && c <= jse_pkg::LEAD2_HI) begin
                    seq_len = 3'd2;
                end else if (c >= jse_pkg::LEAD3_LO && c <= jse_pkg::LEAD3_HI) begin
                    seq_len = 3'd3;
                end else if (c >= jse_pkg::LEAD4_LO && c <= jse_pkg::LEAD4_HI) begin
                    seq_len = 3'd4;
                end else begin
                    put_uesc(c);
                end
                if (c >= jse_pkg::LEAD2_LO && c <= jse_pkg::LEAD4_HI) begin
                    seq_lead     = c;
                    seq_cont_cnt = 2'd0;
                end
            end
        endcase
    endfunction

    function automatic void scan_data(input logic [7:0] c);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = jse_pkg::CONT_LO;
        hi = jse_pkg::CONT_HI;
        if (seq_len == 3'd0) begin
            scan_fresh(c);
            return;
        end
        // The second byte has narrower bounds after some leads.
        if (seq_cont_cnt == 2'd0) begin
            if (seq_lead == jse_pkg::LEAD3_LO) lo = jse_pkg::E0_LO;
            if (seq_lead == jse_pkg::LEAD_ED)  hi = jse_pkg::ED_HI;
            if (seq_lead == jse_pkg::LEAD4_LO) lo = jse_pkg::F0_LO;
            if (seq_lead == jse_pkg::LEAD4_HI) hi = jse_pkg::F4_HI;
        end
        if (c < lo || c > hi) begin
            spill_seq();
            scan_fresh(c);
            return;
        end
        if (3'(seq_cont_cnt) + 3'd2 >= seq_len) begin
            req_chars.push_back(seq_lead);
            for (int k = 0; k < int'(seq_cont_cnt) && k < 2; k++) begin
                req_chars.push_back(seq_cont[k]);
            end
            req_chars.push_back(c);
            drop_seq();
            return;
        end
        if (seq_cont_cnt < 2'd2) begin
            seq_cont[seq_cont_cnt[0]] = c;
            seq_cont_cnt = seq_cont_cnt + 2'd1;
        end
    endfunction

    // Works out the characters of one request and queues them.
    function automatic void predict_request(input logic [1:0] op, input logic [7:0] c);
        req_chars.delete();
        case (op)
            jse_pkg::OP_BEGIN: begin
                drop_seq();
                req_chars.push_back(jse_pkg::CH_QUOTE);
            end
            jse_pkg::OP_DATA: scan_data(c);
            jse_pkg::OP_END: begin
                spill_seq();
                req_chars.push_back(jse_pkg::CH_QUOTE);
            end
            default: ;
        endcase
        foreach (req_chars[k]) begin
            owed_chars.push_back('{ch: req_chars[k], last: (k == req_chars.size() - 1)});
        end
    endfunction

    // Output side is compared before the new request is predicted, since a request
    // accepted at this edge cannot have produced anything yet.
    always @(posedge i_clk) begin
        t_out_char want;
        if (!i_rst_n) begin
            drop_seq();
            owed_chars.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (owed_chars.size() == 0) begin
                    $error("out_byte: no character expected, actual %h", i_out_byte);
                    fails++;
                end else begin
                    want = owed_chars.pop_front();
                    if (i_out_byte !== want.ch) begin
                        $error("out_byte: expected %h, actual %h", want.ch, i_out_byte);
                        fails++;
                    end
                    if (i_last_of_run !== want.last) begin
                        $error("last_of_run: expected %b, actual %b",
                               want.last, i_last_of_run);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_request(i_op, i_data_byte);
            end
        end
        o_fail_count <= fails;
        o_pending    <= owed_chars.size();
    end

endmodule

FILE: bench/json_string_escaper_utf8_check_tb.sv
// Top of the bench for json_string_escaper_utf8_check: drives directed and random strings
// with random idling on both sides and gives the verdict from the checker's count.
// Depends on jse_pkg, the block and json_string_escaper_utf8_check_chk.
`timescale 1ns / 1ps

module json_string_escaper_utf8_check_tb;

    localparam int IDLE_LIMIT   = 400;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 110;
    localparam int CALM_AFTER   = 90;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [1:0] i_op        = jse_pkg::OP_BEGIN;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;

    int fail_count;
    int chars_owed;
    int idle_cycles = 0;
    int stall_left  = 0;
    int sent_items  = 0;
    bit calm        = 1'b0;

    json_string_escaper_utf8_check u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_last_of_run(o_last_of_run)
    );

    json_string_escaper_utf8_check_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_data_byte  (i_data_byte),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_byte   (o_out_byte),
        .i_last_of_run(o_last_of_run),
        .o_fail_count (fail_count),
        .o_pending    (chars_owed)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side stalls in random bursts until the calm part of the run.
    always @(posedge i_clk) begin
        if (calm) begin
            stall_left = 0;
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Ends the run when nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("json_string_escaper_utf8_check_tb: FAIL");
            $finish;
        end
    end

    // Offers one request, possibly after an idle burst, and waits until it is taken.
    task automatic send_req(input logic [1:0] op, input logic [7:0] b);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        if (op != OP_RESERVED) begin
            sent_items++;
        end
        if (sent_items >= CALM_AFTER) begin
            calm <= 1'b1;
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_req(jse_pkg::OP_DATA, b);
    endtask

    // Sends a lead byte and n_cont in-range continuations of a len-byte sequence.
    task automatic send_utf8(input int len, input int n_cont);
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        case (len)
            2:       lead = 8'($urandom_range(jse_pkg::LEAD2_LO, jse_pkg::LEAD2_HI));
            3:       lead = 8'($urandom_range(jse_pkg::LEAD3_LO, jse_pkg::LEAD3_HI));
            default: lead = 8'($urandom_range(jse_pkg::LEAD4_LO, jse_pkg::LEAD4_HI));
        endcase
        lo = jse_pkg::CONT_LO;
        hi = jse_pkg::CONT_HI;
        if (lead == jse_pkg::LEAD3_LO) lo = jse_pkg::E0_LO;
        if (lead == jse_pkg::LEAD_ED)  hi = jse_pkg::ED_HI;
        if (lead == jse_pkg::LEAD4_LO) lo = jse_pkg::F0_LO;
        if (lead == jse_pkg::LEAD4_HI) hi = jse_pkg::F4_HI;
        send_byte(lead);
        for (int k = 0; k < n_cont; k++) begin
            if (k == 0) begin
                send_byte(8'($urandom_range(lo, hi)));
            end else begin
                send_byte(8'($urandom_range(jse_pkg::CONT_LO, jse_pkg::CONT_HI)));
            end
        end
    endtask

    initial begin
        int chunks;
        int len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every short escape, control and ASCII extremes, stray bytes,
        // the narrowed second-byte bounds, the longest broken sequence, a reserved
        // request, begin and end while a sequence is held.
        send_req(jse_pkg::OP_BEGIN, 8'hFF);
        send_byte(jse_pkg::CH_QUOTE);
        send_byte(jse_pkg::CH_BSL);
        send_byte(jse_pkg::CH_NL);
        send_byte(jse_pkg::CH_TAB);
        send_byte(jse_pkg::CH_CR);
        send_byte(8'h00);
        send_byte(8'h1F);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'hC2);
        send_byte(8'h80);
        send_byte(8'hE0);
        send_byte(8'h9F);
        send_byte(8'hED);
        send_byte(8'hA0);
        send_byte(8'hF4);
        send_byte(8'h8F);
        send_byte(8'hBF);
        send_byte(8'hBF);
        send_byte(8'hF1);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'hE1);
        send_req(OP_RESERVED, 8'h5A);
        send_req(jse_pkg::OP_BEGIN, 8'h00);
        send_byte(8'hF0);
        send_byte(8'h90);
        send_req(jse_pkg::OP_END, 8'hA5);

        // Random strings: mostly well-formed text with random content, some noise.
        while (sent_items < RANDOM_ITEMS) begin
            send_req(jse_pkg::OP_BEGIN, 8'($urandom));
            chunks = $urandom_range(1, 6);
            repeat (chunks) begin
                case ($urandom_range(0, 9))
                    0, 1: send_byte(8'($urandom_range(8'h20, 8'h7E)));
                    2: begin
                        case ($urandom_range(0, 6))
                            0: send_byte(jse_pkg::CH_QUOTE);
                            1: send_byte(jse_pkg::CH_BSL);
                            2: send_byte(jse_pkg::CH_NL);
                            3: send_byte(jse_pkg::CH_TAB);
                            4: send_byte(jse_pkg::CH_CR);
                            5: send_byte(8'h7F);
                            default: send_byte(8'($urandom_range(8'h00, 8'h1F)));
                        endcase
                    end
                    3, 4, 5: begin
                        len = $urandom_range(2, 4);
                        send_utf8(len, len - 1);
                    end
                    6: begin
                        len = $urandom_range(2, 4);
                        send_utf8(len, $urandom_range(0, len - 2));
                        send_byte(8'($urandom));
                    end
                    7: begin
                        // Left held so that the end or a begin meets it.
                        len = $urandom_range(2, 4);
                        send_utf8(len, $urandom_range(0, len - 2));
                    end
                    8: send_byte(8'($urandom_range(8'h80, 8'hFF)));
                    default: begin
                        if ($urandom_range(0, 1) == 0) begin
                            send_req(OP_RESERVED, 8'($urandom));
                        end else begin
                            send_req(jse_pkg::OP_BEGIN, 8'($urandom));
                        end
                    end
                endcase
            end
            send_req(jse_pkg::OP_END, 8'($urandom));
        end
        i_in_valid <= 1'b0;

        // Drain, then give the block time to show anything unexpected.
        do @(posedge i_clk); while (chars_owed != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("json_string_escaper_utf8_check_tb: PASS");
        end else begin
            $display("json_string_escaper_utf8_check_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/jse_pkg.sv
sv/jse_decode.sv
sv/jse_emit.sv
sv/json_string_escaper_utf8_check.sv
bench/json_string_escaper_utf8_check_chk.sv
bench/json_string_escaper_utf8_check_tb.sv
